[rtl/core/srlrb_pkg.sv]
// Shared types and constants for the serial receive line ring buffer.
package srlrb_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Operation codes of an input transaction.
  localparam logic [OP_W-1:0] OP_STORE = 2'd0;
  localparam logic [OP_W-1:0] OP_POLL  = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;

  // Status codes of a result transaction.
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LINE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RAW      = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_KEPT_CHAR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_KEPT_CHAR  = 2'd2;

  // Configuration reset values.
  localparam logic [BYTE_W-1:0] END_CHAR_RST        = 8'd13;
  localparam logic [BYTE_W-1:0] FIRST_KEPT_CHAR_RST = 8'd32;
  localparam logic [BYTE_W-1:0] LAST_KEPT_CHAR_RST  = 8'd126;

  // One result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data_byte;
    logic                data_valid;
    logic                last;
  } result_t;

endpackage

[rtl/core/srlrb_if.sv]
// Valid/ready channel interfaces for the command and result sides.
interface srlrb_cmd_if import srlrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, operation, rx_byte, input ready);
  modport sink (input valid, operation, rx_byte, output ready);
endinterface

interface srlrb_rsp_if import srlrb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   data_byte;
  logic                data_valid;
  logic                last;

  modport source (output valid, status, data_byte, data_valid, last, input ready);
  modport sink (input valid, status, data_byte, data_valid, last, output ready);
endinterface

[rtl/core/serial_rx_line_ring_buffer_core.sv]
// Top level of the serial receive ring buffer with line extraction.
//
// Channels: cmd takes one transaction per operation (store a received byte,
// poll for a line, drain all bytes); rsp returns result transactions; a plain
// write port (cfg_we, cfg_index, cfg_data) sets the end character and the
// kept character range. All handshakes complete where valid and ready are high.
// A store gives no result and leaves the sequencer idle, so cmd stays ready.
// A poll on an empty buffer and a drain on an empty buffer answer with one
// result, visible the cycle after acceptance.
// A poll first walks the stored bytes for the end character, one byte per
// cycle from the single RAM read port; when a line is found a second walk
// emits the kept bytes at up to one per cycle, then the closing result. A
// drain emits one byte per cycle once its first RAM read has returned.
// The rate is set by the one RAM read per cycle and by the receiver: while rsp
// stalls, the walk holds with the fetched byte parked in the RAM read register.
// cmd is ready only while no poll or drain is in progress and the result
// register is free or being taken.
// Reset clears the pointers, the overflow flag and the configuration to its
// defaults; the byte store itself is not cleared and needs no clearing pass.
module serial_rx_line_ring_buffer_core import srlrb_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  srlrb_cmd_if.sink            cmd,
  srlrb_rsp_if.source          rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LINE,
    S_DRAIN,
    S_RESULT
  } state_t;

  state_t            state;
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW-1:0]     walk;
  logic              pending;
  logic              overflow;
  logic [BYTE_W-1:0] end_char;
  logic [BYTE_W-1:0] first_kept_char;
  logic [BYTE_W-1:0] last_kept_char;
  result_t           out_q;
  logic              out_valid;
  result_t           fin_q;

  logic              accept;
  logic              out_free;
  logic              hit_end;
  logic              kept;
  logic              more;
  logic              consume;
  logic              issue;
  logic              ram_we;
  logic [BYTE_W-1:0] rd_data;
  logic [AW-1:0]     wr_ptr_next;

  // Wrap-around increment that also works for depths that are not a power of two.
  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(BUFFER_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  assign cmd.ready      = (state == S_IDLE) && out_free;
  assign accept         = cmd.valid && cmd.ready;
  assign out_free       = !out_valid || rsp.ready;
  assign wr_ptr_next    = next_ptr(wr_ptr);

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_q.status;
  assign rsp.data_byte  = out_q.data_byte;
  assign rsp.data_valid = out_q.data_valid;
  assign rsp.last       = out_q.last;

  // Byte store.
  assign ram_we = accept && (cmd.operation == OP_STORE);

  srlrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (cmd.rx_byte),
    .re    (issue),
    .raddr (walk),
    .rdata (rd_data)
  );

  // Decide whether the fetched byte is used this cycle and whether the next is read.
  always_comb begin
    hit_end = (rd_data == end_char);
    kept    = (rd_data >= first_kept_char) && (rd_data <= last_kept_char);
    more    = (walk != wr_ptr);
    consume = 1'b0;
    issue   = 1'b0;
    unique case (state)
      S_SCAN: begin
        consume = pending;
        issue   = (!pending || !hit_end) && more;
      end
      S_LINE: begin
        consume = pending && (out_free || hit_end || !kept);
        issue   = (!pending || (consume && !hit_end)) && more;
      end
      S_DRAIN: begin
        consume = pending && out_free;
        issue   = (!pending || consume) && more;
      end
      S_IDLE, S_RESULT: begin
        consume = 1'b0;
        issue   = 1'b0;
      end
      default: begin
        consume = 1'b0;
        issue   = 1'b0;
      end
    endcase
  end

  // Sequencer, pointers, configuration and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      pending         <= 1'b0;
      overflow        <= 1'b0;
      out_valid       <= 1'b0;
      end_char        <= END_CHAR_RST;
      first_kept_char <= FIRST_KEPT_CHAR_RST;
      last_kept_char  <= LAST_KEPT_CHAR_RST;
    end else begin
      // Configuration writes; indexes beyond the list are ignored.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_END_CHAR:        end_char        <= cfg_data;
          CFG_FIRST_KEPT_CHAR: first_kept_char <= cfg_data;
          CFG_LAST_KEPT_CHAR:  last_kept_char  <= cfg_data;
          default: ;
        endcase
      end

      // The receiver takes the result; a new load below overrides this.
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      // One RAM read in flight at most.
      if (issue) begin
        walk    <= next_ptr(walk);
        pending <= 1'b1;
      end else if (consume) begin
        pending <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.operation)
              OP_STORE: begin
                wr_ptr <= wr_ptr_next;
                if (wr_ptr_next == rd_ptr) begin
                  overflow <= 1'b1;
                end
              end
              OP_POLL: begin
                if (rd_ptr == wr_ptr) begin
                  out_q     <= '{status: (overflow ? ST_OVERFLOW : ST_NONE),
                                 data_byte: '0, data_valid: 1'b0, last: 1'b1};
                  out_valid <= 1'b1;
                  overflow  <= 1'b0;
                end else begin
                  walk  <= rd_ptr;
                  state <= S_SCAN;
                end
              end
              OP_DRAIN: begin
                if (rd_ptr == wr_ptr) begin
                  out_q     <= '{status: ST_NONE, data_byte: '0,
                                 data_valid: 1'b0, last: 1'b1};
                  out_valid <= 1'b1;
                end else begin
                  walk  <= rd_ptr;
                  state <= S_DRAIN;
                end
              end
              default: ;
            endcase
          end
        end

        S_SCAN: begin
          if (consume && hit_end) begin
            // A line is present: restart the walk at the read pointer.
            walk    <= rd_ptr;
            pending <= 1'b0;
            state   <= S_LINE;
          end else if (!more && (!pending || consume)) begin
            fin_q <= '{status: ST_NONE, data_byte: '0, data_valid: 1'b0, last: 1'b1};
            state <= S_RESULT;
          end
        end

        S_LINE: begin
          if (consume) begin
            if (hit_end) begin
              // The walk already points past the terminator.
              rd_ptr <= walk;
              fin_q  <= '{status: ST_LINE, data_byte: '0, data_valid: 1'b0, last: 1'b1};
              state  <= S_RESULT;
            end else if (kept) begin
              out_q     <= '{status: ST_LINE, data_byte: rd_data,
                             data_valid: 1'b1, last: 1'b0};
              out_valid <= 1'b1;
            end
          end
        end

        S_DRAIN: begin
          if (consume) begin
            out_q     <= '{status: ST_RAW, data_byte: rd_data,
                           data_valid: 1'b1, last: !more};
            out_valid <= 1'b1;
            if (!more) begin
              rd_ptr <= wr_ptr;
              state  <= S_IDLE;
            end
          end
        end

        S_RESULT: begin
          if (out_free) begin
            out_q     <= fin_q;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // A result without data always carries a zero byte.
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.data_valid) |-> (rsp.data_byte == '0))
    else $error("result without data carries a nonzero byte");

  // The overflow flag rises only after a stored byte.
  a_overflow_src: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow) |-> $past(accept && (cmd.operation == OP_STORE)))
    else $error("overflow flag set without a store");

  // A RAM read is outstanding only while a walk is in progress.
  a_pending_walk: assert property (@(posedge clk) disable iff (rst)
    pending |-> (state == S_SCAN || state == S_LINE || state == S_DRAIN))
    else $error("read outstanding outside a walk");

  // Both pointers stay inside the buffer.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr <= AW'(BUFFER_DEPTH - 1)) && (rd_ptr <= AW'(BUFFER_DEPTH - 1)))
    else $error("pointer beyond buffer depth");

endmodule

[rtl/core/srlrb_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module srlrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read data that holds while no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
